// ===== hw/rtl/flow_budget_valve_sequencer_macros.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef FLOW_BUDGET_VALVE_SEQUENCER_MACROS_SVH
`define FLOW_BUDGET_VALVE_SEQUENCER_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define FBVS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbvs: same-cycle check failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define FBVS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbvs: next-cycle check failed");

`endif

// ===== hw/rtl/fbvs_pkg.sv =====
package fbvs_pkg;

  // Fixed geometry of the node table and the item fields.
  localparam int SLOTS       = 8;
  localparam int SLOT_W      = 3;
  localparam int SECTORS_DEF = 8;
  localparam int ID_W        = 4;
  localparam int TIME_W      = 16;
  localparam int FLOW_W      = 10;
  localparam int MIN_W       = 11;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;

  // Operation codes of an input item.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // Run modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_FLOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLIC    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_END = 2'd2;

  // Reset values and the minute that means unknown or no end.
  localparam logic [MIN_W-1:0]  MINUTE_NONE   = 11'd1440;
  localparam logic [FLOW_W-1:0] PUMP_FLOW_RST = 10'd30;
  localparam logic [MIN_W-1:0]  CYCLE_END_RST = 11'd1440;

  typedef struct packed {
    logic [1:0]        operation;
    logic [SLOT_W-1:0] node_slot;
    logic              node_used;
    logic [ID_W-1:0]   node_sector;
    logic [ID_W-1:0]   node_parent;
    logic [TIME_W-1:0] node_run_time;
    logic [TIME_W-1:0] node_delay;
    logic [FLOW_W-1:0] node_flow;
    logic [MIN_W-1:0]  now_minute;
  } in_item_t;

  typedef struct packed {
    logic [7:0] valve_mask;
    logic       pump_on;
    logic [1:0] block_mode;
    logic [7:0] done_mask;
    logic       start_accepted;
  } out_item_t;

endpackage

// ===== hw/rtl/flow_budget_valve_sequencer.sv =====
// Flow-budget valve sequencer over a tree of up to eight table nodes.
// Input items (valid/ready) carry one operation: a one-second tick, a node
// load, a start or a stop. Every item yields exactly one result item
// (valid/ready) with the open valves, pump state, run mode, done sectors and,
// for a start, whether anything was scheduled. The configuration port takes
// plain writes (cfg_we, cfg_index, cfg_data); the user must write it only while
// the block is idle, which the block itself does not enforce. One item is
// worked at a time by a small sequencer around a shared flow-budget check;
// in_ready is high only between items. A load walks the ancestor chain of
// all 16 sector ids. Each budget check sums the flows of the open sectors one
// per cycle. A tick takes up to 3 * (SECTORS + 1) list steps, SLOTS + 1 slot
// steps per finished sector and one budget check per admission; a start takes
// SLOTS + 1 slot steps plus its budget checks. A stop or an idle tick goes
// straight to the result state.
// The next item is taken while a result still waits; a stalled receiver
// only holds the finished result and the block after it.
// Reset (rst, synchronous) empties the node table and all lists, sets the
// block idle and restores pump_flow 30, cyclic_mode 0, cycle_end_minute 1440.
`include "flow_budget_valve_sequencer_macros.svh"

module flow_budget_valve_sequencer #(
  parameter int SECTORS = fbvs_pkg::SECTORS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fbvs_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fbvs_pkg::out_item_t                out_item,
  input  logic                               cfg_we,
  input  logic [fbvs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbvs_pkg::CFG_W-1:0]         cfg_data
);

  localparam int MW    = SECTORS;
  localparam int IW    = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int CW    = $clog2(SECTORS + 1);
  localparam int HW    = $clog2(SECTORS + 2);
  localparam int SUM_W = fbvs_pkg::FLOW_W + CW;
  localparam int IDS   = 1 << fbvs_pkg::ID_W;
  localparam int SL    = fbvs_pkg::SLOTS;
  localparam int SW    = fbvs_pkg::SLOT_W;
  localparam int DW    = fbvs_pkg::ID_W;
  localparam int TW    = fbvs_pkg::TIME_W;
  localparam int FW    = fbvs_pkg::FLOW_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PRE, ST_P_SCAN, ST_P_USE, ST_P_PACK, ST_A_SCAN, ST_D_CHK,
    ST_D_USE, ST_C_SCAN, ST_C_USE, ST_END, ST_R_SCAN, ST_R_USE, ST_R_DONE,
    ST_FIT_OPEN, ST_FIT_SUM, ST_FIN
  } state_t;

  state_t state, ret;

  // Node table.
  logic          tab_used [SL];
  logic [DW-1:0] tab_sec  [SL];
  logic [DW-1:0] tab_par  [SL];
  logic [TW-1:0] tab_run  [SL];
  logic [TW-1:0] tab_dly  [SL];
  logic [FW-1:0] tab_flow [SL];

  // Per-id ancestor masks and per-sector flows, rebuilt after each load.
  logic [MW-1:0] anc    [IDS];
  logic [FW-1:0] flow_b [MW];

  // Active, pending and waiting lists.
  logic [DW-1:0] act_sec [MW];
  logic [TW-1:0] act_rem [MW];
  logic [CW-1:0] act_cnt;
  logic [DW-1:0] pnd_sec [MW];
  logic [TW-1:0] pnd_dly [MW];
  logic [TW-1:0] pnd_run [MW];
  logic [CW-1:0] pnd_cnt;
  logic [MW-1:0] pnd_drop;
  logic [DW-1:0] q_sec [MW];
  logic [TW-1:0] q_dly [MW];
  logic [TW-1:0] q_run [MW];
  logic [IW-1:0] q_head;
  logic [CW-1:0] q_cnt;
  logic [DW-1:0] fin_sec [MW];
  logic [CW-1:0] fin_cnt;

  logic [MW-1:0] completed;
  logic [1:0]    run_mode;
  logic [FW-1:0] pump_flow;
  logic          cyclic_mode;
  logic [fbvs_pkg::MIN_W-1:0] cycle_end;

  fbvs_pkg::in_item_t cur;

  // Sequencer counters.
  logic [CW-1:0] pi, pw, ai, aw, fi, fb;
  logic [SW:0]   si;
  logic          from_start, accepted;

  // Shared budget check.
  logic [DW-1:0]    fit_sector;
  logic [MW-1:0]    fit_open;
  logic [SUM_W-1:0] fit_sum;
  logic             fit_ok;

  // Ancestor walk.
  logic [DW-1:0] wk_root, wk_id;
  logic [HW-1:0] wk_hops;
  logic [MW-1:0] wk_mask;
  logic          wk_first;

  function automatic logic [MW-1:0] bit_of(input logic [DW-1:0] id);
    logic [MW-1:0] m;
    m = '0;
    for (int b = 0; b < MW; b++) begin
      if ({1'b0, id} == (DW+1)'(b + 1)) m[b] = 1'b1;
    end
    return m;
  endfunction

  logic [IW-1:0] pix, aix, fix, fbix, wix, q_tail, q_head_inc;
  logic [CW:0]   q_sum, q_sum1;
  assign pix  = pi[IW-1:0];
  assign aix  = ai[IW-1:0];
  assign fix  = fi[IW-1:0];
  assign fbix = fb[IW-1:0];
  assign wix  = pw[IW-1:0];

  // Circular queue tail and next head.
  always_comb begin
    q_sum  = (CW+1)'(q_head) + (CW+1)'(q_cnt);
    q_sum1 = (CW+1)'(q_head) + (CW+1)'(1);
    if (q_sum >= (CW+1)'(SECTORS)) q_sum = q_sum - (CW+1)'(SECTORS);
    if (q_sum1 >= (CW+1)'(SECTORS)) q_sum1 = q_sum1 - (CW+1)'(SECTORS);
    q_tail     = q_sum[IW-1:0];
    q_head_inc = q_sum1[IW-1:0];
  end

  // List masks, valve pipes and the active check of the pending entry.
  logic [MW-1:0] act_mask, act_anc, pnd_mask, fit_set, fit_open_c;
  logic          is_act;
  always_comb begin
    act_mask = '0;
    act_anc  = '0;
    pnd_mask = '0;
    is_act   = 1'b0;
    for (int i = 0; i < MW; i++) begin
      if (CW'(i) < act_cnt) begin
        act_mask = act_mask | bit_of(act_sec[i]);
        act_anc  = act_anc | anc[act_sec[i]];
        if (act_sec[i] == pnd_sec[pix]) is_act = 1'b1;
      end
      if (CW'(i) < pnd_cnt) pnd_mask = pnd_mask | bit_of(pnd_sec[i]);
    end
    fit_set    = act_mask | pnd_mask | bit_of(fit_sector);
    fit_open_c = fit_set;
    for (int b = 0; b < MW; b++) begin
      if (fit_set[b] && (b + 1) < IDS) fit_open_c = fit_open_c | anc[DW'(b + 1)];
    end
  end

  // Lowest used slot holding the walked id.
  logic          f_hit;
  logic [SW-1:0] f_slot;
  always_comb begin
    f_hit  = 1'b0;
    f_slot = '0;
    for (int s = SL - 1; s >= 0; s--) begin
      if (tab_used[s] && tab_sec[s] == wk_id) begin
        f_hit  = 1'b1;
        f_slot = SW'(s);
      end
    end
  end

  // Single table read port.
  logic [SW-1:0] tab_addr;
  logic          tr_used;
  logic [DW-1:0] tr_sec, tr_par;
  logic [TW-1:0] tr_run, tr_dly;
  logic [FW-1:0] tr_flow;
  assign tab_addr = (state == ST_PRE) ? f_slot : si[SW-1:0];
  assign tr_used  = tab_used[tab_addr];
  assign tr_sec   = tab_sec[tab_addr];
  assign tr_par   = tab_par[tab_addr];
  assign tr_run   = tab_run[tab_addr];
  assign tr_dly   = tab_dly[tab_addr];
  assign tr_flow  = tab_flow[tab_addr];

  logic any_used;
  always_comb begin
    any_used = 1'b0;
    for (int s = 0; s < SL; s++) any_used = any_used | tab_used[s];
  end

  // Admission request of the current step.
  logic          adm_go, adm_fit;
  logic [DW-1:0] adm_sec;
  logic [TW-1:0] adm_run, adm_dly;
  always_comb begin
    adm_go  = 1'b0;
    adm_fit = fit_ok;
    adm_sec = tr_sec;
    adm_run = tr_run;
    adm_dly = '0;
    case (state)
      ST_P_USE: begin
        adm_go  = 1'b1;
        adm_sec = pnd_sec[pix];
        adm_run = pnd_run[pix];
      end
      ST_D_USE: begin
        adm_go  = fit_ok;
        adm_fit = 1'b1;
        adm_sec = q_sec[q_head];
        adm_run = q_run[q_head];
        adm_dly = q_dly[q_head];
      end
      ST_C_USE: begin
        adm_go  = 1'b1;
        adm_dly = tr_dly;
      end
      ST_R_USE: begin
        adm_go = 1'b1;
      end
      default: begin
        adm_go = 1'b0;
      end
    endcase
  end

  // Ancestor walk step values.
  logic [MW-1:0] wk_mask_add;
  logic [HW-1:0] wk_hops_n;
  logic          wk_stop, wk_root_in;
  assign wk_mask_add = wk_mask | bit_of(tr_par);
  assign wk_hops_n   = wk_hops + HW'(1);
  assign wk_stop     = !f_hit || tr_par == '0;
  assign wk_root_in  = wk_root != '0 && int'(wk_root) <= SECTORS;

  logic all_zero, may_restart;
  assign all_zero = act_cnt == '0 && pnd_cnt == '0 && q_cnt == '0;
  assign may_restart = cur.now_minute >= fbvs_pkg::MINUTE_NONE ||
                       cycle_end >= fbvs_pkg::MINUTE_NONE || cur.now_minute < cycle_end;

  // Result of the finished item.
  logic [MW+7:0] valves_ext, done_ext;
  fbvs_pkg::out_item_t out_next;
  always_comb begin
    valves_ext = {8'b0, act_mask | ((run_mode == fbvs_pkg::MODE_RUN) ? act_anc : '0)};
    done_ext   = {8'b0, completed};
    out_next.valve_mask     = valves_ext[7:0];
    out_next.pump_on        = act_mask != '0;
    out_next.block_mode     = run_mode;
    out_next.done_mask      = done_ext[7:0];
    out_next.start_accepted = accepted;
  end

  assign in_ready = state == ST_IDLE;

  // Sequencer, lists, table and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ret         <= ST_IDLE;
      run_mode    <= fbvs_pkg::MODE_IDLE;
      act_cnt     <= '0;
      pnd_cnt     <= '0;
      q_cnt       <= '0;
      q_head      <= '0;
      fin_cnt     <= '0;
      completed   <= '0;
      pump_flow   <= fbvs_pkg::PUMP_FLOW_RST;
      cyclic_mode <= 1'b0;
      cycle_end   <= fbvs_pkg::CYCLE_END_RST;
      out_valid   <= 1'b0;
      accepted    <= 1'b0;
      from_start  <= 1'b0;
      for (int s = 0; s < SL; s++) tab_used[s] <= 1'b0;
      for (int d = 0; d < IDS; d++) anc[d] <= '0;
      for (int b = 0; b < MW; b++) flow_b[b] <= '0;
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        case (cfg_index)
          fbvs_pkg::REG_PUMP_FLOW: begin
            if (cfg_data[FW-1:0] != '0) pump_flow <= cfg_data[FW-1:0];
          end
          fbvs_pkg::REG_CYCLIC:    cyclic_mode <= cfg_data[0];
          fbvs_pkg::REG_CYCLE_END: cycle_end <= cfg_data;
          default: begin
          end
        endcase
      end

      // A taken result frees the output register unless a new one lands now.
      if (out_valid && out_ready && state != ST_FIN) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur      <= in_item;
            accepted <= 1'b0;
            case (in_item.operation)
              fbvs_pkg::OP_TICK: begin
                pi    <= '0;
                state <= (run_mode == fbvs_pkg::MODE_RUN) ? ST_P_SCAN : ST_FIN;
              end
              fbvs_pkg::OP_LOAD: begin
                tab_used[in_item.node_slot] <= in_item.node_used;
                tab_sec[in_item.node_slot]  <= in_item.node_sector;
                tab_par[in_item.node_slot]  <= in_item.node_parent;
                tab_run[in_item.node_slot]  <= in_item.node_run_time;
                tab_dly[in_item.node_slot]  <= in_item.node_delay;
                tab_flow[in_item.node_slot] <= in_item.node_flow;
                wk_root  <= '0;
                wk_id    <= '0;
                wk_hops  <= '0;
                wk_mask  <= '0;
                wk_first <= 1'b1;
                state    <= ST_PRE;
              end
              fbvs_pkg::OP_START: begin
                if (any_used) begin
                  run_mode   <= fbvs_pkg::MODE_RUN;
                  from_start <= 1'b1;
                  act_cnt    <= '0;
                  pnd_cnt    <= '0;
                  q_cnt      <= '0;
                  completed  <= '0;
                  si         <= '0;
                  state      <= ST_R_SCAN;
                end else begin
                  state <= ST_FIN;
                end
              end
              default: begin
                run_mode  <= fbvs_pkg::MODE_STOP;
                act_cnt   <= '0;
                pnd_cnt   <= '0;
                q_cnt     <= '0;
                completed <= '0;
                state     <= ST_FIN;
              end
            endcase
          end
        end

        // One hop of the ancestor walk of wk_root per cycle.
        ST_PRE: begin
          if (wk_first && wk_root_in) begin
            flow_b[IW'(wk_root - DW'(1))] <= f_hit ? tr_flow : '0;
          end
          if (wk_stop || wk_hops_n > HW'(SECTORS)) begin
            anc[wk_root] <= wk_stop ? wk_mask : wk_mask_add;
            if (wk_root == DW'(IDS - 1)) begin
              state <= ST_FIN;
            end else begin
              wk_root  <= wk_root + DW'(1);
              wk_id    <= wk_root + DW'(1);
              wk_hops  <= '0;
              wk_mask  <= '0;
              wk_first <= 1'b1;
            end
          end else begin
            wk_mask  <= wk_mask_add;
            wk_hops  <= wk_hops_n;
            wk_id    <= tr_par;
            wk_first <= 1'b0;
          end
        end

        // Count down pending delays; expired entries are admitted or queued, or dropped if already active.
        ST_P_SCAN: begin
          if (pi == pnd_cnt) begin
            pi    <= '0;
            pw    <= '0;
            state <= ST_P_PACK;
          end else if (pnd_dly[pix] <= TW'(1)) begin
            pnd_drop[pix] <= 1'b1;
            if (is_act) begin
              pi <= pi + CW'(1);
            end else begin
              fit_sector <= pnd_sec[pix];
              ret        <= ST_P_USE;
              state      <= ST_FIT_OPEN;
            end
          end else begin
            pnd_dly[pix]  <= pnd_dly[pix] - TW'(1);
            pnd_drop[pix] <= 1'b0;
            pi            <= pi + CW'(1);
          end
        end

        ST_P_USE: begin
          pi    <= pi + CW'(1);
          state <= ST_P_SCAN;
        end

        // Squeeze out the expired pending entries.
        ST_P_PACK: begin
          if (pi == pnd_cnt) begin
            pnd_cnt <= pw;
            ai      <= '0;
            aw      <= '0;
            fin_cnt <= '0;
            state   <= ST_A_SCAN;
          end else begin
            if (!pnd_drop[pix]) begin
              pnd_sec[wix] <= pnd_sec[pix];
              pnd_dly[wix] <= pnd_dly[pix];
              pnd_run[wix] <= pnd_run[pix];
              pw           <= pw + CW'(1);
            end
            pi <= pi + CW'(1);
          end
        end

        // Count down run times; finished sectors are collected in order.
        ST_A_SCAN: begin
          if (ai == act_cnt) begin
            act_cnt <= aw;
            state   <= ST_D_CHK;
          end else begin
            if (act_rem[aix] <= TW'(1)) begin
              fin_sec[fin_cnt[IW-1:0]] <= act_sec[aix];
              fin_cnt   <= fin_cnt + CW'(1);
              completed <= completed | bit_of(act_sec[aix]);
            end else begin
              act_sec[aw[IW-1:0]] <= act_sec[aix];
              act_rem[aw[IW-1:0]] <= act_rem[aix] - TW'(1);
              aw <= aw + CW'(1);
            end
            ai <= ai + CW'(1);
          end
        end

        // Drain the wait queue from its head while the budget allows.
        ST_D_CHK: begin
          if (q_cnt == '0) begin
            fi    <= '0;
            si    <= '0;
            state <= ST_C_SCAN;
          end else begin
            fit_sector <= q_sec[q_head];
            ret        <= ST_D_USE;
            state      <= ST_FIT_OPEN;
          end
        end

        ST_D_USE: begin
          if (fit_ok) begin
            q_head <= q_head_inc;
            q_cnt  <= q_cnt - CW'(1);
            state  <= ST_D_CHK;
          end else begin
            fi    <= '0;
            si    <= '0;
            state <= ST_C_SCAN;
          end
        end

        // Admit the children of each finished sector, slot by slot.
        ST_C_SCAN: begin
          if (fi == fin_cnt) begin
            state <= ST_END;
          end else if (si == (SW+1)'(SL)) begin
            si <= '0;
            fi <= fi + CW'(1);
          end else if (tr_used && tr_par == fin_sec[fix]) begin
            fit_sector <= tr_sec;
            ret        <= ST_C_USE;
            state      <= ST_FIT_OPEN;
          end else begin
            si <= si + (SW+1)'(1);
          end
        end

        ST_C_USE: begin
          si    <= si + (SW+1)'(1);
          state <= ST_C_SCAN;
        end

        // With all lists empty: restart in cyclic mode if the window allows, else fall idle.
        ST_END: begin
          if (all_zero) begin
            if (cyclic_mode && may_restart) begin
              from_start <= 1'b0;
              completed  <= '0;
              si         <= '0;
              state      <= ST_R_SCAN;
            end else begin
              run_mode  <= fbvs_pkg::MODE_IDLE;
              completed <= '0;
              state     <= ST_FIN;
            end
          end else begin
            state <= ST_FIN;
          end
        end

        // Admit every root of the table.
        ST_R_SCAN: begin
          if (si == (SW+1)'(SL)) begin
            state <= ST_R_DONE;
          end else if (tr_used && tr_par == '0) begin
            fit_sector <= tr_sec;
            ret        <= ST_R_USE;
            state      <= ST_FIT_OPEN;
          end else begin
            si <= si + (SW+1)'(1);
          end
        end

        ST_R_USE: begin
          si    <= si + (SW+1)'(1);
          state <= ST_R_SCAN;
        end

        ST_R_DONE: begin
          if (from_start) begin
            if (all_zero) begin
              run_mode  <= fbvs_pkg::MODE_IDLE;
              completed <= '0;
            end else begin
              accepted <= 1'b1;
            end
          end
          state <= ST_FIN;
        end

        // Shared budget check: open pipes, then a serial flow sum.
        ST_FIT_OPEN: begin
          fit_open <= fit_open_c;
          fit_sum  <= '0;
          fb       <= '0;
          state    <= ST_FIT_SUM;
        end

        ST_FIT_SUM: begin
          if (fb == CW'(SECTORS)) begin
            fit_ok <= fit_sum <= SUM_W'(pump_flow);
            state  <= ret;
          end else begin
            if (fit_open[fbix]) fit_sum <= fit_sum + SUM_W'(flow_b[fbix]);
            fb <= fb + CW'(1);
          end
        end

        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_item  <= out_next;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Place an admitted or refused sector on its list; full lists drop it.
      if (adm_go) begin
        if (adm_fit) begin
          if (adm_dly != '0) begin
            if (pnd_cnt < CW'(SECTORS)) begin
              pnd_sec[pnd_cnt[IW-1:0]] <= adm_sec;
              pnd_dly[pnd_cnt[IW-1:0]] <= adm_dly;
              pnd_run[pnd_cnt[IW-1:0]] <= adm_run;
              pnd_cnt <= pnd_cnt + CW'(1);
            end
          end else if (act_cnt < CW'(SECTORS)) begin
            act_sec[act_cnt[IW-1:0]] <= adm_sec;
            act_rem[act_cnt[IW-1:0]] <= adm_run;
            act_cnt <= act_cnt + CW'(1);
          end
        end else if (q_cnt < CW'(SECTORS)) begin
          q_sec[q_tail] <= adm_sec;
          q_dly[q_tail] <= adm_dly;
          q_run[q_tail] <= adm_run;
          q_cnt <= q_cnt + CW'(1);
        end
      end
    end
  end

  // List counts never pass the list depth.
  `FBVS_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, act_cnt <= CW'(SECTORS) && pnd_cnt <= CW'(SECTORS) && q_cnt <= CW'(SECTORS))
  // An accepted item keeps the block busy on the next cycle.
  `FBVS_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // A start that scheduled something leaves the block running.
  `FBVS_ASSERT_IMP(a_start_runs, clk, rst, out_valid && out_item.start_accepted, out_item.block_mode == fbvs_pkg::MODE_RUN)
  // Outside a run, between items, all lists are empty.
  `FBVS_ASSERT_IMP(a_idle_empty, clk, rst, state == ST_IDLE && run_mode != fbvs_pkg::MODE_RUN, act_cnt == '0 && pnd_cnt == '0 && q_cnt == '0)

endmodule

// ===== sim/flow_budget_valve_sequencer_tb.sv =====
`timescale 1ns / 100ps

// Prediction of the sequencer: a private copy of the node table, the run lists,
// the registers and the results still owed by the block.
class valve_scoreboard;
  typedef struct {
    bit        used;
    bit [3:0]  sector;
    bit [3:0]  parent;
    bit [15:0] run;
    bit [15:0] delay;
    bit [9:0]  flow;
  } slot_t;
  typedef struct {
    bit [3:0]  sector;
    bit [15:0] remaining;
  } run_t;
  typedef struct {
    bit [3:0]  sector;
    bit [15:0] delay;
    bit [15:0] run;
    bit [9:0]  flow;
  } wait_t;

  slot_t     tbl[8];
  run_t      act[8];
  wait_t     pend[8];
  wait_t     wq[8];
  int        act_n, pend_n, wq_n;
  bit [7:0]  done;
  bit [1:0]  mode;
  bit [9:0]  pump_flow;
  bit        cyclic;
  bit [10:0] end_minute;
  fbvs_pkg::out_item_t owed[$];
  int        errors, checked;
  int        op_count[4];

  function new();
    foreach (tbl[i]) tbl[i] = '{default: 0};
    act_n = 0; pend_n = 0; wq_n = 0; done = 0; mode = fbvs_pkg::MODE_IDLE;
    pump_flow = fbvs_pkg::PUMP_FLOW_RST; cyclic = 0; end_minute = fbvs_pkg::CYCLE_END_RST;
    errors = 0; checked = 0;
    foreach (op_count[i]) op_count[i] = 0;
  endfunction

  function void set_reg(bit [1:0] idx, bit [10:0] data);
    if (idx == fbvs_pkg::REG_PUMP_FLOW) begin
      // A zero budget is not taken.
      if (data[9:0] != 0) pump_flow = data[9:0];
    end else if (idx == fbvs_pkg::REG_CYCLIC) begin
      cyclic = data[0];
    end else if (idx == fbvs_pkg::REG_CYCLE_END) begin
      end_minute = data;
    end
  endfunction

  function bit [7:0] bit_of(bit [3:0] id);
    return (id >= 1 && id <= 8) ? 8'(1 << (id - 1)) : 8'd0;
  endfunction

  // Lowest used slot holding a sector, -1 if none.
  function int find_slot(bit [3:0] id);
    for (int i = 0; i < 8; i++)
      if (tbl[i].used && tbl[i].sector == id) return i;
    return -1;
  endfunction

  // Pipes above a sector; the walk gives up after a bounded hop count.
  function bit [7:0] pipes_above(bit [3:0] id);
    bit [7:0] m;
    int n, hops;
    m = 0; hops = 0;
    n = find_slot(id);
    while (n >= 0 && tbl[n].parent != 0) begin
      m |= bit_of(tbl[n].parent);
      hops++;
      if (hops > 8) break;
      n = find_slot(tbl[n].parent);
    end
    return m;
  endfunction

  function int flow_of(bit [7:0] set);
    bit [7:0] open;
    int total, n;
    open = set; total = 0;
    for (int id = 1; id <= 8; id++)
      if (set & bit_of(4'(id))) open |= pipes_above(4'(id));
    for (int id = 1; id <= 8; id++)
      if (open & bit_of(4'(id))) begin
        n = find_slot(4'(id));
        if (n >= 0) total += tbl[n].flow;
      end
    return total;
  endfunction

  function bit [7:0] active_bits();
    bit [7:0] m;
    m = 0;
    for (int i = 0; i < act_n; i++) m |= bit_of(act[i].sector);
    return m;
  endfunction

  function bit fits(bit [3:0] id);
    bit [7:0] m;
    m = active_bits() | bit_of(id);
    for (int i = 0; i < pend_n; i++) m |= bit_of(pend[i].sector);
    return flow_of(m) <= pump_flow;
  endfunction

  function void add_active(bit [3:0] id, bit [15:0] run);
    if (act_n >= 8) return;
    act[act_n] = '{id, run};
    act_n++;
  endfunction

  function void add_pending(wait_t e);
    if (pend_n >= 8) return;
    pend[pend_n] = e;
    pend_n++;
  endfunction

  function void add_queue(wait_t e);
    if (wq_n >= 8) return;
    wq[wq_n] = e;
    wq_n++;
  endfunction

  function void admit(bit [3:0] id, bit [15:0] run, bit [9:0] flow, bit [15:0] delay);
    wait_t e;
    e = '{id, delay, run, flow};
    if (fits(id)) begin
      if (delay > 0) add_pending(e);
      else add_active(id, run);
    end else begin
      add_queue(e);
    end
  endfunction

  function void clear_run(bit [1:0] m);
    mode = m; act_n = 0; pend_n = 0; wq_n = 0; done = 0;
  endfunction

  function void open_roots();
    act_n = 0; pend_n = 0; wq_n = 0; done = 0;
    for (int i = 0; i < 8; i++)
      if (tbl[i].used && tbl[i].parent == 0)
        admit(tbl[i].sector, tbl[i].run, tbl[i].flow, 16'd0);
  endfunction

  // Move queued sectors out in order while the head fits the budget.
  function void drain_queue();
    wait_t e;
    while (wq_n > 0 && fits(wq[0].sector)) begin
      e = wq[0];
      for (int i = 0; i < wq_n - 1; i++) wq[i] = wq[i + 1];
      wq_n--;
      if (e.delay > 0) add_pending(e);
      else add_active(e.sector, e.run);
    end
  endfunction

  function bit is_active(bit [3:0] id);
    for (int i = 0; i < act_n; i++)
      if (act[i].sector == id) return 1;
    return 0;
  endfunction

  // One second: delays run out, sectors finish, children are admitted.
  function void one_second(bit [10:0] now);
    wait_t    keep_p[8];
    run_t     keep_a[8];
    bit [3:0] fin[8];
    int       nk, nf, old_n;
    wait_t    e;
    bit       may;
    nk = 0; nf = 0;
    old_n = pend_n;
    for (int i = 0; i < old_n; i++) begin
      e = pend[i];
      if (e.delay <= 1) begin
        if (!is_active(e.sector)) begin
          if (fits(e.sector)) add_active(e.sector, e.run);
          else add_queue('{e.sector, 16'd0, e.run, e.flow});
        end
      end else begin
        e.delay--;
        keep_p[nk++] = e;
      end
    end
    pend_n = nk;
    for (int i = 0; i < nk; i++) pend[i] = keep_p[i];
    nk = 0;
    for (int i = 0; i < act_n; i++) begin
      if (act[i].remaining <= 1) fin[nf++] = act[i].sector;
      else keep_a[nk++] = '{act[i].sector, act[i].remaining - 16'd1};
    end
    act_n = nk;
    for (int i = 0; i < nk; i++) act[i] = keep_a[i];
    for (int i = 0; i < nf; i++) done |= bit_of(fin[i]);
    drain_queue();
    for (int i = 0; i < nf; i++)
      for (int s = 0; s < 8; s++)
        if (tbl[s].used && tbl[s].parent == fin[i])
          admit(tbl[s].sector, tbl[s].run, tbl[s].flow, tbl[s].delay);
    if (act_n == 0 && pend_n == 0 && wq_n == 0) begin
      may = now >= fbvs_pkg::MINUTE_NONE || end_minute >= fbvs_pkg::MINUTE_NONE ||
            now < end_minute;
      if (cyclic && may) open_roots();
      else clear_run(fbvs_pkg::MODE_IDLE);
    end
  endfunction

  // An accepted input item: update the state and owe one result.
  function void note_input(fbvs_pkg::in_item_t it);
    fbvs_pkg::out_item_t r;
    bit        any, accepted;
    bit [7:0]  valves;
    accepted = 0;
    op_count[it.operation]++;
    case (it.operation)
      fbvs_pkg::OP_TICK: begin
        if (mode == fbvs_pkg::MODE_RUN) one_second(it.now_minute);
      end
      fbvs_pkg::OP_LOAD: begin
        tbl[it.node_slot] = '{it.node_used, it.node_sector, it.node_parent,
                              it.node_run_time, it.node_delay, it.node_flow};
      end
      fbvs_pkg::OP_START: begin
        any = 0;
        foreach (tbl[i]) if (tbl[i].used) any = 1;
        if (any) begin
          mode = fbvs_pkg::MODE_RUN;
          open_roots();
          if (act_n == 0 && pend_n == 0 && wq_n == 0) clear_run(fbvs_pkg::MODE_IDLE);
          else accepted = 1;
        end
      end
      default: clear_run(fbvs_pkg::MODE_STOP);
    endcase
    valves = active_bits();
    if (mode == fbvs_pkg::MODE_RUN)
      for (int i = 0; i < act_n; i++) valves |= pipes_above(act[i].sector);
    r.valve_mask     = valves;
    r.pump_on        = active_bits() != 0;
    r.block_mode     = mode;
    r.done_mask      = done;
    r.start_accepted = accepted;
    owed.push_back(r);
  endfunction

  task report(string what, int got, int want);
    $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // A result from the block, compared with the oldest one owed.
  task check(fbvs_pkg::out_item_t got);
    fbvs_pkg::out_item_t want;
    if (owed.size() == 0) begin
      report("result with nothing owed, valve_mask", got.valve_mask, 0);
      return;
    end
    want = owed.pop_front();
    checked++;
    if (got.valve_mask !== want.valve_mask) report("valve_mask", got.valve_mask, want.valve_mask);
    if (got.pump_on !== want.pump_on) report("pump_on", got.pump_on, want.pump_on);
    if (got.block_mode !== want.block_mode) report("block_mode", got.block_mode, want.block_mode);
    if (got.done_mask !== want.done_mask) report("done_mask", got.done_mask, want.done_mask);
    if (got.start_accepted !== want.start_accepted)
      report("start_accepted", got.start_accepted, want.start_accepted);
  endtask
endclass

module flow_budget_valve_sequencer_tb;
  localparam int STALL_LIMIT = 20000;

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  fbvs_pkg::in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 0;
  fbvs_pkg::out_item_t out_item;
  logic      cfg_we = 0;
  logic [fbvs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fbvs_pkg::CFG_W-1:0]     cfg_data = '0;

  valve_scoreboard sb = new();
  bit idle_en = 1;
  bit hold_req = 0;
  int sent = 0;
  int quiet_cycles = 0;

  flow_budget_valve_sequencer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Accepted items on both channels go to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check(out_item);
      if (in_valid && in_ready) sb.note_input(in_item);
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
      $display("flow_budget_valve_sequencer regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ready <= !idle_en || $urandom_range(99) >= 32;
      end
    end
  end

  // Offer one item and return at the edge that takes it; valid stays high.
  task automatic send(fbvs_pkg::in_item_t it);
    if (idle_en && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
  endtask

  // Stop offering and let every owed result arrive, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic [fbvs_pkg::CFG_IDX_W-1:0] idx,
                           logic [fbvs_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  function automatic fbvs_pkg::in_item_t make_item(logic [1:0] op);
    fbvs_pkg::in_item_t it;
    it = '0;
    it.operation = op;
    case ($urandom_range(3))
      0: it.now_minute = 11'($urandom_range(2047));
      1: it.now_minute = fbvs_pkg::MINUTE_NONE;
      default: it.now_minute = 11'($urandom_range(1439));
    endcase
    return it;
  endfunction

  function automatic fbvs_pkg::in_item_t make_node(int slot, bit used, int sec, int par,
                                                   int run, int dly, int flow);
    fbvs_pkg::in_item_t it;
    it = make_item(fbvs_pkg::OP_LOAD);
    it.node_slot = 3'(slot);
    it.node_used = used;
    it.node_sector = 4'(sec);
    it.node_parent = 4'(par);
    it.node_run_time = 16'(run);
    it.node_delay = 16'(dly);
    it.node_flow = 10'(flow);
    return it;
  endfunction

  // Random load with every field over its full width.
  function automatic fbvs_pkg::in_item_t wild_node();
    return make_node($urandom_range(7), $urandom_range(1), $urandom_range(15),
                     $urandom_range(15), $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(1023));
  endfunction

  // A fresh tree with short times, mostly well formed.
  task automatic load_tree();
    int sec, par;
    for (int s = 0; s < 8; s++) begin
      sec = ($urandom_range(99) < 92) ? $urandom_range(1, 8) : $urandom_range(0, 15);
      par = (s == 0 || $urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(99) < 4) par = $urandom_range(9, 15);
      send(make_node(s, $urandom_range(99) < 85, sec, par, $urandom_range(1, 4),
                     $urandom_range(0, 2), $urandom_range(0, 14)));
    end
  endtask

  // Start the loaded tree and tick it, with some noise mixed in.
  task automatic run_tree(int ticks);
    int pick;
    send(make_item(fbvs_pkg::OP_START));
    for (int i = 0; i < ticks; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) send(make_item(fbvs_pkg::OP_STOP));
      else if (pick < 6) send(make_item(fbvs_pkg::OP_START));
      else if (pick < 9) send(wild_node());
      else send(make_item(fbvs_pkg::OP_TICK));
    end
  endtask

  task automatic random_phase(int items);
    int goal;
    goal = sent + items;
    while (sent < goal) begin
      load_tree();
      run_tree($urandom_range(10, 30));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle tick, empty start, a small tree with a queued root,
    // out-of-range and duplicate sectors, a parent loop and widest fields.
    send(make_item(fbvs_pkg::OP_TICK));
    send(make_item(fbvs_pkg::OP_START));
    send(make_node(0, 1, 1, 0, 2, 0, 10));
    send(make_node(1, 1, 2, 1, 1, 1, 10));
    send(make_node(2, 1, 3, 0, 1, 0, 25));
    send(make_node(3, 1, 0, 0, 1, 0, 0));
    send(make_node(4, 1, 15, 3, 65535, 65535, 1023));
    send(make_node(5, 1, 2, 2, 3, 0, 1));
    send(make_node(6, 1, 8, 7, 1, 0, 2));
    send(make_node(7, 1, 7, 8, 1, 0, 2));
    send(make_item(fbvs_pkg::OP_START));
    repeat (5) send(make_item(fbvs_pkg::OP_TICK));
    send(make_item(fbvs_pkg::OP_START));
    send(make_item(fbvs_pkg::OP_TICK));
    send(make_item(fbvs_pkg::OP_STOP));
    send(make_item(fbvs_pkg::OP_TICK));
    send(make_node(4, 0, 0, 0, 0, 0, 0));
    send(make_node(7, 0, 15, 15, 65535, 65535, 1023));
    wait_drained();

    // Phase with the smallest budget, cyclic restarts with no window end.
    write_reg(fbvs_pkg::REG_PUMP_FLOW, '0);
    write_reg(fbvs_pkg::REG_PUMP_FLOW, 11'd1);
    write_reg(fbvs_pkg::REG_CYCLIC, 11'd1);
    write_reg(fbvs_pkg::REG_CYCLE_END, fbvs_pkg::MINUTE_NONE);
    random_phase(80);
    wait_drained();

    // Largest budget and an empty restart window; no idling, and the
    // receiver holds off long enough for the block to back up.
    write_reg(fbvs_pkg::REG_PUMP_FLOW, 11'd1023);
    write_reg(fbvs_pkg::REG_CYCLE_END, 11'd0);
    idle_en = 0;
    load_tree();
    hold_req = 1;
    run_tree(30);
    random_phase(60);
    idle_en = 1;
    wait_drained();

    // Middle budget, window ending mid-day, then widest end value, one-shot.
    write_reg(fbvs_pkg::REG_PUMP_FLOW, 11'($urandom_range(8, 40)));
    write_reg(fbvs_pkg::REG_CYCLE_END, 11'($urandom_range(1, 1439)));
    random_phase(100);
    wait_drained();
    write_reg(fbvs_pkg::REG_CYCLIC, 11'd0);
    write_reg(fbvs_pkg::REG_CYCLE_END, 11'd2047);
    write_reg(fbvs_pkg::REG_PUMP_FLOW, 11'd30);
    random_phase(100);

    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Run covered %0d items: %0d ticks, %0d loads, %0d starts, %0d stops,",
             sent, sb.op_count[fbvs_pkg::OP_TICK], sb.op_count[fbvs_pkg::OP_LOAD],
             sb.op_count[fbvs_pkg::OP_START], sb.op_count[fbvs_pkg::OP_STOP]);
    $display("across five register settings; %0d results checked, %0d mismatches.",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("flow_budget_valve_sequencer regression: pass");
    end else begin
      $display("flow_budget_valve_sequencer regression: fail");
    end
    $finish;
  end
endmodule
